/* design/improved_perlin_noise_3d_defines.svh */
// ----------------------------------------------------------------------------
// Improved Perlin noise assertion macros
// Shared concurrent assertion forms for the noise block checkers.
// ----------------------------------------------------------------------------
`ifndef IMPROVED_PERLIN_NOISE_3D_DEFINES_SVH
`define IMPROVED_PERLIN_NOISE_3D_DEFINES_SVH

`define IPN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

`define IPN_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant check failed");

`endif

/* design/ipn_pkg.sv */
// ----------------------------------------------------------------------------
// Improved Perlin noise package
// Shared types and constants for the noise pipeline.
// ----------------------------------------------------------------------------
package ipn_pkg;

    localparam int CFG_WIDTH       = 24;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int COORD_WIDTH     = 32;
    localparam int CELL_WIDTH      = 8;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_X_OFFSET = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_Y_OFFSET = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_Z_OFFSET = 2'd2;

    // A permutation table write travelling down the pipeline.
    typedef struct packed {
        logic                  wr;
        logic [CELL_WIDTH-1:0] idx;
        logic [CELL_WIDTH-1:0] val;
    } ipn_wr_t;

endpackage

/* design/ipn_perm_ram.sv */
// ----------------------------------------------------------------------------
// Permutation table copy
// One write port and two registered read ports over 256 bytes.
// ----------------------------------------------------------------------------
module ipn_perm_ram
    import ipn_pkg::*;
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [CELL_WIDTH-1:0] waddr,
    input  logic [CELL_WIDTH-1:0] wdata,
    input  logic [CELL_WIDTH-1:0] raddr0,
    input  logic [CELL_WIDTH-1:0] raddr1,
    output logic [CELL_WIDTH-1:0] rdata0,
    output logic [CELL_WIDTH-1:0] rdata1
);

    logic [CELL_WIDTH-1:0] mem [1 << CELL_WIDTH];
    logic [CELL_WIDTH-1:0] rdata0_reg;
    logic [CELL_WIDTH-1:0] rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0_reg <= mem[raddr0];
        rdata1_reg <= mem[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

/* design/ipn_fade.sv */
// ----------------------------------------------------------------------------
// Fade curve pipeline
// Three register stages computing 6t^5 - 15t^4 + 10t^3 in fixed point.
// ----------------------------------------------------------------------------
module ipn_fade #(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic [FRAC_BITS-1:0] t,
    output logic [FRAC_BITS:0]   fade
);

    localparam int PW = FRAC_BITS + 5;
    localparam logic [PW-1:0] TEN_ONE = PW'(10) << FRAC_BITS;

    logic [FRAC_BITS-1:0]   t2_reg;
    logic [FRAC_BITS-1:0]   t_d_reg;
    logic [FRAC_BITS-1:0]   t3_reg;
    logic [FRAC_BITS+3:0]   p_reg;
    logic [FRAC_BITS:0]     fade_reg;
    logic [2*FRAC_BITS-1:0] sq;
    logic [2*FRAC_BITS-1:0] cube;
    logic [PW-1:0]          e2;
    logic [PW-1:0]          et;
    logic [PW-1:0]          p_next;
    logic [2*FRAC_BITS+3:0] fp;

    always_comb
    begin
        sq     = {{FRAC_BITS{1'b0}}, t} * {{FRAC_BITS{1'b0}}, t};
        cube   = {{FRAC_BITS{1'b0}}, t2_reg} * {{FRAC_BITS{1'b0}}, t_d_reg};
        e2     = {5'd0, t2_reg};
        et     = {5'd0, t_d_reg};
        p_next = (e2 << 2) + (e2 << 1) + TEN_ONE - (et << 4) + et;
        fp     = {{(FRAC_BITS+4){1'b0}}, t3_reg} * {{FRAC_BITS{1'b0}}, p_reg};
    end

    always_ff @(posedge clk)
    begin
        t2_reg   <= sq[2*FRAC_BITS-1:FRAC_BITS];
        t_d_reg  <= t;
        t3_reg   <= cube[2*FRAC_BITS-1:FRAC_BITS];
        p_reg    <= p_next[FRAC_BITS+3:0];
        fade_reg <= fp[2*FRAC_BITS:FRAC_BITS];
    end

    assign fade = fade_reg;

endmodule

/* design/ipn_hash.sv */
// ----------------------------------------------------------------------------
// Corner hash pipeline
// Three levels of replicated permutation lookups giving eight corner hashes.
// ----------------------------------------------------------------------------
module ipn_hash
    import ipn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ipn_wr_t               wr1,
    input  logic [CELL_WIDTH-1:0] cx,
    input  logic [CELL_WIDTH-1:0] cy,
    input  logic [CELL_WIDTH-1:0] cz,
    output logic [CELL_WIDTH-1:0] hash [8]
);

    ipn_wr_t               wr2_reg;
    ipn_wr_t               wr3_reg;
    logic [CELL_WIDTH-1:0] cy2_reg;
    logic [CELL_WIDTH-1:0] cz2_reg;
    logic [CELL_WIDTH-1:0] cz3_reg;
    logic [CELL_WIDTH-1:0] pa;
    logic [CELL_WIDTH-1:0] pb;
    logic [CELL_WIDTH-1:0] addr_a;
    logic [CELL_WIDTH-1:0] addr_b;
    logic [CELL_WIDTH-1:0] lvl2 [4];
    logic [CELL_WIDTH-1:0] addr3 [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr2_reg <= '0;
            wr3_reg <= '0;
        end
        else
        begin
            wr2_reg <= wr1;
            wr3_reg <= wr2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cy2_reg <= cy;
        cz2_reg <= cz;
        cz3_reg <= cz2_reg;
    end

    ipn_perm_ram u_ram1 (
        .clk    (clk),
        .we     (wr1.wr),
        .waddr  (wr1.idx),
        .wdata  (wr1.val),
        .raddr0 (cx),
        .raddr1 (cx + 8'd1),
        .rdata0 (pa),
        .rdata1 (pb)
    );

    assign addr_a = pa + cy2_reg;
    assign addr_b = pb + cy2_reg;

    ipn_perm_ram u_ram2a (
        .clk    (clk),
        .we     (wr2_reg.wr),
        .waddr  (wr2_reg.idx),
        .wdata  (wr2_reg.val),
        .raddr0 (addr_a),
        .raddr1 (addr_a + 8'd1),
        .rdata0 (lvl2[0]),
        .rdata1 (lvl2[2])
    );

    ipn_perm_ram u_ram2b (
        .clk    (clk),
        .we     (wr2_reg.wr),
        .waddr  (wr2_reg.idx),
        .wdata  (wr2_reg.val),
        .raddr0 (addr_b),
        .raddr1 (addr_b + 8'd1),
        .rdata0 (lvl2[1]),
        .rdata1 (lvl2[3])
    );

    // Copies hold aa, ba, ab, bb; corner bit 2 selects the next z cell.
    for (genvar k = 0; k < 4; k++)
    begin : g_lvl3
        assign addr3[k] = lvl2[k] + cz3_reg;

        ipn_perm_ram u_ram3 (
            .clk    (clk),
            .we     (wr3_reg.wr),
            .waddr  (wr3_reg.idx),
            .wdata  (wr3_reg.val),
            .raddr0 (addr3[k]),
            .raddr1 (addr3[k] + 8'd1),
            .rdata0 (hash[k]),
            .rdata1 (hash[k+4])
        );
    end

endmodule

/* design/improved_perlin_noise_3d.sv */
// ----------------------------------------------------------------------------
// Improved Perlin noise 3D
// Each accepted evaluate request gives a done strobe with its noise value.
// One request is accepted every cycle; busy stays low and loads give no result.
// The pipeline is the input register, three permutation lookup levels,
// the gradient stage and three blend stages; the fade curve runs alongside.
// Reset clears the offsets and the pipeline valid bits; the table is not reset.
// ----------------------------------------------------------------------------
module improved_perlin_noise_3d
    import ipn_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        cmd,
    input  logic [CELL_WIDTH-1:0]       table_index,
    input  logic [CELL_WIDTH-1:0]       table_value,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_WIDTH-1:0]        cfg_data,
    output logic                        done,
    output logic signed [FRAC_BITS+1:0] noise_value
);

    localparam int LW = FRAC_BITS + 3;
    localparam int OW = FRAC_BITS + 2;

    function automatic logic signed [LW-1:0] grad(
        input logic [3:0]                  h,
        input logic signed [FRAC_BITS:0]   dx,
        input logic signed [FRAC_BITS:0]   dy,
        input logic signed [FRAC_BITS:0]   dz
    );
        logic signed [LW-1:0] ex;
        logic signed [LW-1:0] ey;
        logic signed [LW-1:0] ez;
        logic signed [LW-1:0] ga;
        logic signed [LW-1:0] gb;
        ex = $signed({{2{dx[FRAC_BITS]}}, dx});
        ey = $signed({{2{dy[FRAC_BITS]}}, dy});
        ez = $signed({{2{dz[FRAC_BITS]}}, dz});
        ga = (h < 4'd8) ? ex : ey;
        gb = (h < 4'd4) ? ey : ((h == 4'd12 || h == 4'd14) ? ex : ez);
        return (h[0] ? -ga : ga) + (h[1] ? -gb : gb);
    endfunction

    function automatic logic signed [LW-1:0] lerp(
        input logic [FRAC_BITS:0]   s,
        input logic signed [LW-1:0] a,
        input logic signed [LW-1:0] b
    );
        logic signed [LW:0]             d;
        logic signed [LW+FRAC_BITS+1:0] prod;
        logic signed [LW+FRAC_BITS+1:0] sh;
        d    = $signed({b[LW-1], b}) - $signed({a[LW-1], a});
        prod = $signed({{(FRAC_BITS+1){d[LW]}}, d}) * $signed({{(LW+1){1'b0}}, s});
        sh   = prod >>> FRAC_BITS;
        return a + $signed(sh[LW-1:0]);
    endfunction

    logic                  accept;
    logic [CFG_WIDTH-1:0]  off_reg [3];
    logic [COORD_WIDTH-1:0] coord [3];
    logic [COORD_WIDTH-1:0] sum [3];
    ipn_wr_t               wr1_reg;
    logic [7:0]            valid_reg;
    logic [CELL_WIDTH-1:0] cell1_reg [3];
    logic [FRAC_BITS-1:0]  frac1_reg [3];
    logic [FRAC_BITS-1:0]  frac2_reg [3];
    logic [FRAC_BITS-1:0]  frac3_reg [3];
    logic [FRAC_BITS-1:0]  frac4_reg [3];
    logic [FRAC_BITS:0]    fade5 [3];
    logic [FRAC_BITS:0]    v6_reg;
    logic [FRAC_BITS:0]    w6_reg;
    logic [FRAC_BITS:0]    w7_reg;
    logic [CELL_WIDTH-1:0] hash4 [8];
    logic signed [LW-1:0]  grad5_reg [8];
    logic signed [LW-1:0]  lerp6_reg [4];
    logic signed [LW-1:0]  lerp7_reg [2];
    logic signed [LW-1:0]  mix8;
    logic signed [OW-1:0]  out_reg;

    assign accept = start && !busy;
    assign busy   = 1'b0;
    assign coord[0] = coord_x;
    assign coord[1] = coord_y;
    assign coord[2] = coord_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg[0] <= '0;
            off_reg[1] <= '0;
            off_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_X_OFFSET: off_reg[0] <= cfg_data;
                REG_Y_OFFSET: off_reg[1] <= cfg_data;
                REG_Z_OFFSET: off_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            wr1_reg   <= '0;
        end
        else
        begin
            valid_reg   <= {valid_reg[6:0], accept && !cmd};
            wr1_reg.wr  <= accept && cmd;
            wr1_reg.idx <= table_index;
            wr1_reg.val <= table_value;
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_axis
        assign sum[k] = coord[k] + {{(COORD_WIDTH-CFG_WIDTH){1'b0}}, off_reg[k]};

        always_ff @(posedge clk)
        begin
            cell1_reg[k] <= sum[k][FRAC_BITS+CELL_WIDTH-1:FRAC_BITS];
            frac1_reg[k] <= sum[k][FRAC_BITS-1:0];
            frac2_reg[k] <= frac1_reg[k];
            frac3_reg[k] <= frac2_reg[k];
            frac4_reg[k] <= frac3_reg[k];
        end

        ipn_fade #(.FRAC_BITS(FRAC_BITS)) u_fade (
            .clk  (clk),
            .t    (frac2_reg[k]),
            .fade (fade5[k])
        );
    end

    ipn_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .wr1   (wr1_reg),
        .cx    (cell1_reg[0]),
        .cy    (cell1_reg[1]),
        .cz    (cell1_reg[2]),
        .hash  (hash4)
    );

    // Corner bit 0 is the x side, bit 1 the y side, bit 2 the z side.
    for (genvar i = 0; i < 8; i++)
    begin : g_corner
        always_ff @(posedge clk)
        begin
            grad5_reg[i] <= grad(hash4[i][3:0],
                                 $signed({((i & 1) != 0) ? 1'b1 : 1'b0, frac4_reg[0]}),
                                 $signed({((i & 2) != 0) ? 1'b1 : 1'b0, frac4_reg[1]}),
                                 $signed({((i & 4) != 0) ? 1'b1 : 1'b0, frac4_reg[2]}));
        end
    end

    for (genvar j = 0; j < 4; j++)
    begin : g_lerp_u
        always_ff @(posedge clk)
        begin
            lerp6_reg[j] <= lerp(fade5[0], grad5_reg[2*j], grad5_reg[2*j+1]);
        end
    end

    always_ff @(posedge clk)
    begin
        v6_reg       <= fade5[1];
        w6_reg       <= fade5[2];
        w7_reg       <= w6_reg;
        lerp7_reg[0] <= lerp(v6_reg, lerp6_reg[0], lerp6_reg[1]);
        lerp7_reg[1] <= lerp(v6_reg, lerp6_reg[2], lerp6_reg[3]);
        if (mix8[LW-1] != mix8[LW-2])
        begin
            out_reg <= {mix8[LW-1], {(OW-1){~mix8[LW-1]}}};
        end
        else
        begin
            out_reg <= mix8[OW-1:0];
        end
    end

    assign mix8        = lerp(w7_reg, lerp7_reg[0], lerp7_reg[1]);
    assign done        = valid_reg[7];
    assign noise_value = out_reg;

endmodule

/* design/ipn_checker.sv */
// ----------------------------------------------------------------------------
// Improved Perlin noise port checker
// Checks that busy stays low, and request timing against the done strobe at the top level ports.
// ----------------------------------------------------------------------------
`include "improved_perlin_noise_3d_defines.svh"

module ipn_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic cmd,
    input logic done
);

    `IPN_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)
    `IPN_ASSERT_IMPL(a_eval_done, clk, rst_n, start && !busy && !cmd, ##8 done)
    `IPN_ASSERT_IMPL(a_load_silent, clk, rst_n, start && !busy && cmd, ##8 !done)
    `IPN_ASSERT_IMPL(a_done_source, clk, rst_n, done, $past(start && !busy && !cmd, 8))

endmodule

bind improved_perlin_noise_3d ipn_checker u_ipn_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done)
);
